// ===== src/sobs_pkg.sv =====
// Shared types, widths and codes for the set of bounded stacks.
package sobs_pkg;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 3;
    localparam int CAP_W   = 5;
    localparam int USE_W   = 4;
    localparam int TOTAL_W = 8;
    localparam int CFG_W   = 5;

    // Default geometry
    localparam int DEF_NUM_STACKS  = 8;
    localparam int DEF_STACK_DEPTH = 16;

    // Register reset values
    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [USE_W-1:0] USED_RESET = 4'd8;

    // Value returned by a peek that finds nothing
    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // Configuration register indexes
    typedef enum logic {
        CFG_CAPACITY = 1'b0,
        CFG_STACKS   = 1'b1
    } t_cfg_idx;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_POP_AT = 2'd3
    } t_cmd;

    // Outcome of one request, from the fill tracker to the top level
    typedef struct packed {
        logic ok;
        logic inc;
        logic dec;
        logic wr_en;
        logic rd_en;
        logic peek_miss;
    } t_decision;

endpackage

// ===== src/sobs_fill.sv =====
// Fill counters, element total and stack selection for one request per cycle while i_step is high.
module sobs_fill #(
    parameter int NUM_STACKS  = sobs_pkg::DEF_NUM_STACKS,
    parameter int STACK_DEPTH = sobs_pkg::DEF_STACK_DEPTH,
    parameter int AW = (NUM_STACKS * STACK_DEPTH > 1) ?
                       $clog2(NUM_STACKS * STACK_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  sobs_pkg::t_cmd               i_cmd,
    input  logic [sobs_pkg::IDX_W-1:0]   i_idx,
    input  logic [sobs_pkg::CAP_W-1:0]   i_cap,
    input  logic [sobs_pkg::USE_W-1:0]   i_used,
    output sobs_pkg::t_decision          o_dec,
    output logic [AW-1:0]                o_addr,
    output logic [sobs_pkg::TOTAL_W-1:0] o_total_next
);
    import sobs_pkg::*;

    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;
    localparam int SW = $clog2(NUM_STACKS + 1);
    localparam int UW = (SW > USE_W) ? SW : USE_W;
    localparam int XW = (SW > IDX_W) ? SW : IDX_W;
    localparam int IW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    logic [FW-1:0]         r_fill [NUM_STACKS];
    logic [TOTAL_W-1:0]    r_total;
    logic [TOTAL_W-1:0]    n_total;

    logic [CW-1:0]         cap_ext;
    logic [FW-1:0]         cap_eff;
    logic [UW-1:0]         used_ext;
    logic [SW-1:0]         used_eff;
    logic [NUM_STACKS-1:0] can_push;
    logic [NUM_STACKS-1:0] non_empty;
    logic                  any_push;
    logic                  any_top;
    logic [IW-1:0]         push_s;
    logic [IW-1:0]         top_s;
    logic [XW-1:0]         idx_ext;
    logic [IW-1:0]         idx_s;
    logic                  idx_ok;
    logic [IW-1:0]         tgt;
    logic [FW-1:0]         slot;
    t_decision             dec;

    // Clamp the configuration registers into their working range
    always_comb begin
        cap_ext  = CW'(i_cap);
        used_ext = UW'(i_used);
        if (cap_ext == '0) begin
            cap_eff = FW'(1);
        end else if (cap_ext > CW'(STACK_DEPTH)) begin
            cap_eff = FW'(STACK_DEPTH);
        end else begin
            cap_eff = cap_ext[FW-1:0];
        end
        if (used_ext == '0) begin
            used_eff = SW'(1);
        end else if (used_ext > UW'(NUM_STACKS)) begin
            used_eff = SW'(NUM_STACKS);
        end else begin
            used_eff = used_ext[SW-1:0];
        end
    end

    // Flag each stack in use as pushable or non-empty
    always_comb begin
        for (int s = 0; s < NUM_STACKS; s++) begin
            can_push[s]  = (SW'(s) < used_eff) && (r_fill[s] < cap_eff);
            non_empty[s] = (SW'(s) < used_eff) && (r_fill[s] != '0);
        end
    end

    // Lowest pushable stack and highest non-empty stack
    always_comb begin
        push_s = '0;
        top_s  = '0;
        for (int s = NUM_STACKS - 1; s >= 0; s--) begin
            if (can_push[s]) begin
                push_s = IW'(s);
            end
        end
        for (int s = 0; s < NUM_STACKS; s++) begin
            if (non_empty[s]) begin
                top_s = IW'(s);
            end
        end
        any_push = |can_push;
        any_top  = |non_empty;
    end

    // Range check for the named stack of a pop-at
    always_comb begin
        idx_ext = XW'(i_idx);
        idx_s   = idx_ext[IW-1:0];
        idx_ok  = (idx_ext < XW'(used_eff)) && (r_fill[idx_s] != '0);
    end

    // Decide the request's outcome and target stack
    always_comb begin
        dec  = '0;
        tgt  = top_s;
        slot = r_fill[top_s] - FW'(1);
        case (i_cmd)
            CMD_PUSH: begin
                tgt       = push_s;
                slot      = r_fill[push_s];
                dec.ok    = any_push;
                dec.inc   = any_push;
                dec.wr_en = any_push;
            end
            CMD_POP: begin
                dec.ok  = any_top;
                dec.dec = any_top;
            end
            CMD_PEEK: begin
                dec.ok        = any_top;
                dec.rd_en     = any_top;
                dec.peek_miss = !any_top;
            end
            CMD_POP_AT: begin
                tgt     = idx_s;
                dec.ok  = idx_ok;
                dec.dec = idx_ok;
            end
            default: begin
                dec = '0;
            end
        endcase
    end

    // Element address and total after the request
    always_comb begin
        o_addr  = AW'(tgt) * AW'(STACK_DEPTH) + AW'(slot);
        n_total = r_total;
        if (i_step && dec.inc) begin
            n_total = r_total + TOTAL_W'(1);
        end else if (i_step && dec.dec) begin
            n_total = r_total - TOTAL_W'(1);
        end
    end

    assign o_dec        = dec;
    assign o_total_next = n_total;

    // Advance the fill counters and the total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
            r_total <= '0;
        end else begin
            r_total <= n_total;
            if (i_step) begin
                for (int s = 0; s < NUM_STACKS; s++) begin
                    if (IW'(s) == tgt && dec.inc) begin
                        r_fill[s] <= r_fill[s] + FW'(1);
                    end else if (IW'(s) == tgt && dec.dec) begin
                        r_fill[s] <= r_fill[s] - FW'(1);
                    end
                end
            end
        end
    end

endmodule

// ===== src/set_of_bounded_stacks.sv =====
// Set of bounded stacks: a request passes through the input register, then the result register.
// Throughput is one request per cycle while the result side does not stall; the element memory is
// written on a push and read on a peek through a single port with registered read data.
// Reset empties every stack, clears the element total and sets capacity 16
// and eight stacks in use; element storage is not cleared.
// Stalls on the result side back up through the input register.
module set_of_bounded_stacks #(
    parameter int NUM_STACKS  = sobs_pkg::DEF_NUM_STACKS,
    parameter int STACK_DEPTH = sobs_pkg::DEF_STACK_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sobs_pkg::CMD_W-1:0]          i_command,
    input  logic signed [sobs_pkg::VALUE_W-1:0] i_value,
    input  logic [sobs_pkg::IDX_W-1:0]          i_stack_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_ok,
    output logic signed [sobs_pkg::VALUE_W-1:0] o_top_value,
    output logic [sobs_pkg::TOTAL_W-1:0]        o_total_count,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [sobs_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import sobs_pkg::*;

    localparam int DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CAP_W-1:0]          r_cap;
    logic [USE_W-1:0]          r_used;

    logic                      r_in_valid;
    logic [CMD_W-1:0]          r_cmd;
    logic signed [VALUE_W-1:0] r_value;
    logic [IDX_W-1:0]          r_idx;

    logic                      r_out_valid;
    logic                      r_ok;
    logic                      r_peek_hit;
    logic                      r_peek_miss;
    logic [TOTAL_W-1:0]        r_total;
    logic signed [VALUE_W-1:0] r_rdata;

    logic signed [VALUE_W-1:0] mem [DEPTH];

    logic                      advance;
    logic                      step;
    t_decision                 dec;
    logic [AW-1:0]             addr;
    logic [TOTAL_W-1:0]        total_next;

    // Handshake: result register frees the input register
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_used <= USED_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAPACITY: r_cap  <= i_cfg_wdata[CAP_W-1:0];
                CFG_STACKS:   r_used <= i_cfg_wdata[USE_W-1:0];
                default:      r_cap  <= r_cap;
            endcase
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd   <= i_command;
            r_value <= i_value;
            r_idx   <= i_stack_index;
        end
    end

    // Track fills and pick the target stack
    sobs_fill #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_fill (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cmd        (t_cmd'(r_cmd)),
        .i_idx        (r_idx),
        .i_cap        (r_cap),
        .i_used       (r_used),
        .o_dec        (dec),
        .o_addr       (addr),
        .o_total_next (total_next)
    );

    // Element memory: write on push, read on peek
    always_ff @(posedge i_clk) begin
        if (step && dec.wr_en) begin
            mem[addr] <= r_value;
        end
        if (step && dec.rd_en) begin
            r_rdata <= mem[addr];
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ok        <= dec.ok;
            r_peek_hit  <= dec.rd_en;
            r_peek_miss <= dec.peek_miss;
            r_total     <= total_next;
        end
    end

    // Drive the result ports
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_total_count = r_total;
    assign o_top_value   = r_peek_hit  ? r_rdata :
                           r_peek_miss ? INT_MAX : '0;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the set of bounded stacks, with a built-in predictor.
module testbench;
    import sobs_pkg::*;

    localparam int NUM_STACKS  = DEF_NUM_STACKS;
    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] top_value;
        logic [TOTAL_W-1:0]        total_count;
    } t_stack_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_command;
    logic signed [VALUE_W-1:0] i_value;
    logic [IDX_W-1:0]          i_stack_index;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic                      o_ok;
    logic signed [VALUE_W-1:0] o_top_value;
    logic [TOTAL_W-1:0]        o_total_count;
    logic                      i_cfg_we;
    logic                      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_wdata;

    set_of_bounded_stacks u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_stack_index (i_stack_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_top_value   (o_top_value),
        .o_total_count (o_total_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Predicted contents of the stacks and the register settings
    logic signed [VALUE_W-1:0] element_mem [NUM_STACKS][STACK_DEPTH];
    int unsigned               fill_level  [NUM_STACKS];
    logic [TOTAL_W-1:0]        held_total;
    logic [CAP_W-1:0]          capacity_reg;
    logic [USE_W-1:0]          stacks_reg;

    t_stack_result pending_results[$];
    int            error_count;
    bit            no_idling;
    int            hold_off_request;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    // Work out the result of one request and advance the predicted stacks
    function automatic t_stack_result predict_stack_result(input t_cmd cmd,
                                                           input logic signed [VALUE_W-1:0] val,
                                                           input logic [IDX_W-1:0] idx);
        t_stack_result res;
        int cap_eff;
        int used_eff;
        int top_s;
        int s;
        bit placed;
        res.ok        = 1'b0;
        res.top_value = '0;
        cap_eff  = (capacity_reg == 0) ? 1 :
                   (capacity_reg > STACK_DEPTH) ? STACK_DEPTH : int'(capacity_reg);
        used_eff = (stacks_reg == 0) ? 1 :
                   (stacks_reg > NUM_STACKS) ? NUM_STACKS : int'(stacks_reg);
        // Find the highest non-empty stack in use
        top_s = -1;
        for (s = used_eff - 1; s >= 0; s--) begin
            if (top_s < 0 && fill_level[s] != 0) top_s = s;
        end
        case (cmd)
            CMD_PUSH: begin
                placed = 1'b0;
                for (s = 0; s < used_eff; s++) begin
                    if (!placed && fill_level[s] < cap_eff) begin
                        element_mem[s][fill_level[s]] = val;
                        fill_level[s]++;
                        held_total++;
                        res.ok = 1'b1;
                        placed = 1'b1;
                    end
                end
            end
            CMD_POP: begin
                if (top_s >= 0) begin
                    fill_level[top_s]--;
                    held_total--;
                    res.ok = 1'b1;
                end
            end
            CMD_PEEK: begin
                if (top_s >= 0) begin
                    res.top_value = element_mem[top_s][fill_level[top_s] - 1];
                    res.ok        = 1'b1;
                end else begin
                    res.top_value = INT_MAX;
                end
            end
            CMD_POP_AT: begin
                if (int'(idx) < used_eff && fill_level[idx] != 0) begin
                    fill_level[idx]--;
                    held_total--;
                    res.ok = 1'b1;
                end
            end
            default: ;
        endcase
        res.total_count = held_total;
        return res;
    endfunction

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(input t_cmd cmd, input logic signed [VALUE_W-1:0] val,
                                input logic [IDX_W-1:0] idx);
        while (!no_idling && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_value       <= val;
        i_stack_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_stack_result(cmd, val, idx));
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // Hold until every predicted result has arrived and the pipeline is empty
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write capacity then stack count while the block is idle
    task automatic set_geometry(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] used);
        stop_sending();
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        capacity_reg = cap[CAP_W-1:0];
        i_cfg_index <= CFG_STACKS;
        i_cfg_wdata <= used;
        @(posedge i_clk);
        stacks_reg = used[USE_W-1:0];
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(15))
            0:       return INT_MAX;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        return IDX_W'($urandom_range(NUM_STACKS - 1));
    endfunction

    function automatic t_cmd random_command(input int push_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < push_pct) return CMD_PUSH;
        pick = $urandom_range(2);
        if (pick == 0) return CMD_POP;
        if (pick == 1) return CMD_PEEK;
        return CMD_POP_AT;
    endfunction

    // Result side: random stalls, optional long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request > 0) begin
                stall_left       = hold_off_request;
                hold_off_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (no_idling) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 33);
            end
        end
    end

    // Compare each result with the oldest prediction
    initial begin
        t_stack_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result ok=%0b top=%0d total=%0d",
                                              o_ok, o_top_value, o_total_count));
                end else begin
                    want = pending_results.pop_front();
                    if (o_ok !== want.ok)
                        report_mismatch($sformatf("ok %b, want %b", o_ok, want.ok));
                    if (o_top_value !== want.top_value)
                        report_mismatch($sformatf("top_value %0d, want %0d",
                                                  o_top_value, want.top_value));
                    if (o_total_count !== want.total_count)
                        report_mismatch($sformatf("total_count %0d, want %0d",
                                                  o_total_count, want.total_count));
                end
            end
        end
    end

    // Empty set, extreme values and every command at the reset settings
    task automatic test_empty_and_extremes();
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP, random_value(), 3'd5);
        send_request(CMD_POP_AT, random_value(), 3'd0);
        send_request(CMD_POP_AT, random_value(), 3'd7);
        send_request(CMD_PUSH, INT_MAX, 3'd7);
        send_request(CMD_PUSH, 32'sh8000_0000, 3'd2);
        send_request(CMD_PUSH, '0, 3'd1);
        send_request(CMD_PUSH, -32'sd1, 3'd6);
        send_request(CMD_PUSH, 32'sh5555_5555, 3'd3);
        send_request(CMD_PUSH, 32'shAAAA_AAAA, 3'd4);
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP_AT, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP_AT, random_value(), 3'd7);
        repeat (5) send_request(CMD_POP, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
    endtask

    // Register values of zero clamp to one; then capacity and stack count of one
    task automatic test_clamped_registers();
        set_geometry(5'd0, 5'd0);
        send_request(CMD_PUSH, random_value(), 3'd0);
        send_request(CMD_PUSH, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP_AT, random_value(), 3'd1);
        send_request(CMD_POP_AT, random_value(), 3'd0);
        send_request(CMD_POP, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        set_geometry(5'd1, 5'd1);
        send_request(CMD_PUSH, random_value(), 3'd0);
        send_request(CMD_PUSH, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP, random_value(), 3'd0);
    endtask

    // Fill every stack to the limit, then empty the set again
    task automatic test_fill_and_drain();
        int s;
        set_geometry(5'd31, 5'd15);
        repeat (130) send_request(CMD_PUSH, random_value(), random_index());
        send_request(CMD_PEEK, random_value(), 3'd0);
        for (s = 0; s < NUM_STACKS; s++) send_request(CMD_POP_AT, random_value(), IDX_W'(s));
        repeat (125) send_request(CMD_POP, random_value(), random_index());
        send_request(CMD_PEEK, random_value(), 3'd0);
    endtask

    // Shrink both registers while the stacks hold data, then grow them back
    task automatic test_shrink_while_holding();
        set_geometry(5'd16, 5'd8);
        repeat (40) send_request(CMD_PUSH, random_value(), 3'd0);
        set_geometry(5'd4, 5'd2);
        send_request(CMD_PUSH, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        send_request(CMD_POP_AT, random_value(), 3'd2);
        send_request(CMD_POP_AT, random_value(), 3'd1);
        send_request(CMD_POP_AT, random_value(), 3'd0);
        send_request(CMD_POP, random_value(), 3'd0);
        send_request(CMD_PEEK, random_value(), 3'd0);
        set_geometry(5'd16, 5'd8);
        send_request(CMD_PEEK, random_value(), 3'd0);
        repeat (40) send_request(CMD_POP, random_value(), 3'd0);
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        no_idling        = 1'b1;
        hold_off_request = 80;
        repeat (40) send_request(random_command(60), random_value(), random_index());
        no_idling = 1'b0;
    endtask

    // Random command mix over several register settings
    task automatic test_random_traffic();
        int phase;
        int n;
        int push_pct;
        push_pct = 50;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       set_geometry(5'd16, 5'd8);
                1:       set_geometry(5'd1, 5'd8);
                2:       set_geometry(5'd3, 5'd1);
                default: set_geometry(CFG_W'($urandom_range(31)), CFG_W'($urandom_range(15)));
            endcase
            // one phase runs with no idling on either side
            no_idling = (phase == 3);
            for (n = 0; n < 190; n++) begin
                if (n % 25 == 0) push_pct = $urandom_range(15, 85);
                send_request(random_command(push_pct), random_value(), random_index());
            end
        end
        no_idling = 1'b0;
    endtask

    // Reset, run the tests in turn, then judge
    initial begin
        int s;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_PUSH;
        i_value       <= '0;
        i_stack_index <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_CAPACITY;
        i_cfg_wdata   <= '0;
        error_count      = 0;
        no_idling        = 1'b0;
        hold_off_request = 0;
        for (s = 0; s < NUM_STACKS; s++) fill_level[s] = 0;
        held_total   = '0;
        capacity_reg = CAP_RESET;
        stacks_reg   = USED_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_extremes();
        test_clamped_registers();
        test_fill_and_drain();
        test_shrink_while_holding();
        test_output_stall();
        test_random_traffic();

        stop_sending();
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
